[src/mme_pkg.sv]
// Package for the matrix multiply engine: field widths, operation and
// register codes, reset values and the pipeline tag type. No dependencies.
package mme_pkg;

    localparam int MAX_DIM_DEF = 16;

    localparam int VAL_W  = 16;
    localparam int PROD_W = 32;
    localparam int COL_W  = 4;
    localparam int CFG_W  = 5;
    localparam int IDX_W  = 2;

    localparam logic [CFG_W-1:0] DIM_RESET = 5'd16;

    localparam logic OP_LOAD_B = 1'b0;
    localparam logic OP_ROW_A  = 1'b1;

    localparam logic [IDX_W-1:0] REG_INNER_SIZE = 2'd0;
    localparam logic [IDX_W-1:0] REG_OUT_COLS   = 2'd1;
    localparam logic [IDX_W-1:0] REG_LEFT_ROWS  = 2'd2;

    typedef struct packed {
        logic valid;
        logic first;
        logic last;
        logic last_col;
        logic final_row;
    } t_tag;

endpackage

[src/mme_if.sv]
// Channel interfaces of the matrix multiply engine: input items, result
// items and configuration writes. Depends on mme_pkg.
interface mme_in_if;
    logic                              valid;
    logic                              ready;
    logic                              operation;
    logic signed [mme_pkg::VAL_W-1:0]  value;
    modport source (output valid, operation, value, input ready);
    modport sink   (input valid, operation, value, output ready);
endinterface

interface mme_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [mme_pkg::PROD_W-1:0] product;
    logic        [mme_pkg::COL_W-1:0]  column;
    logic                              last;
    logic                              final_row;
    logic                              saturated;
    modport source (output valid, product, column, last, final_row, saturated, input ready);
    modport sink   (input valid, product, column, last, final_row, saturated, output ready);
endinterface

interface mme_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [mme_pkg::IDX_W-1:0]         index;
    logic [mme_pkg::CFG_W-1:0]         data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[src/mme_seq.sv]
// Sequencer: configuration registers, load/fill/row counters and the
// issue loop over columns and inner terms. Depends on mme_pkg, mme_if.
module mme_seq #(
    parameter int MAX_DIM = mme_pkg::MAX_DIM_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    mme_in_if.sink                           i_in,
    mme_cfg_if.sink                          i_cfg,
    input  logic                             i_pipe_en,
    output logic                             o_w_we,
    output logic [$clog2(MAX_DIM*MAX_DIM)-1:0] o_w_waddr,
    output logic                             o_x_we,
    output logic [$clog2(MAX_DIM)-1:0]       o_x_waddr,
    output logic signed [mme_pkg::VAL_W-1:0] o_wdata,
    output mme_pkg::t_tag                    o_tag,
    output logic [$clog2(MAX_DIM*MAX_DIM)-1:0] o_w_raddr,
    output logic [$clog2(MAX_DIM)-1:0]       o_x_raddr,
    output logic [$clog2(MAX_DIM)-1:0]       o_col
);
    localparam int IW = $clog2(MAX_DIM);
    localparam int AW = $clog2(MAX_DIM * MAX_DIM);
    localparam int DW = $clog2(MAX_DIM + 1);
    localparam int TW = 2 * DW;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_RUN  = 1'b1;

    function automatic logic [DW-1:0] f_dim(input logic [mme_pkg::CFG_W-1:0] rv);
        if (rv == '0) begin
            return DW'(1);
        end else if (32'(rv) > MAX_DIM) begin
            return DW'(MAX_DIM);
        end else begin
            return DW'(rv);
        end
    endfunction

    logic                       r_state;
    logic [mme_pkg::CFG_W-1:0]  r_inner_size, r_out_cols, r_left_rows;
    logic [AW-1:0]              r_load_pos;
    logic [IW-1:0]              r_fill_pos;
    logic [IW-1:0]              r_rows_done;
    logic                       r_final;
    logic [IW-1:0]              r_k, r_j;
    logic [AW-1:0]              r_addr;

    logic [DW-1:0] n_in, n_out, n_rows;
    logic [TW-1:0] total, load_inc;
    logic [DW-1:0] fill_inc, rows_inc, k_inc, j_inc;
    logic          in_fire, cfg_fire, cfg_hit;
    logic          row_done, k_end, j_end;

    assign n_in   = f_dim(r_inner_size);
    assign n_out  = f_dim(r_out_cols);
    assign n_rows = f_dim(r_left_rows);

    assign total    = TW'(n_in) * TW'(n_out);
    assign load_inc = TW'(r_load_pos) + TW'(1);
    assign fill_inc = DW'(r_fill_pos) + DW'(1);
    assign rows_inc = DW'(r_rows_done) + DW'(1);
    assign k_inc    = DW'(r_k) + DW'(1);
    assign j_inc    = DW'(r_j) + DW'(1);
    assign row_done = fill_inc >= n_in;
    assign k_end    = k_inc >= n_in;
    assign j_end    = j_inc >= n_out;

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign in_fire     = i_in.valid && i_in.ready;
    assign cfg_fire    = i_cfg.valid && i_cfg.ready;
    assign cfg_hit     = (i_cfg.index == mme_pkg::REG_INNER_SIZE)
                      || (i_cfg.index == mme_pkg::REG_OUT_COLS)
                      || (i_cfg.index == mme_pkg::REG_LEFT_ROWS);

    assign o_w_we    = in_fire && (i_in.operation == mme_pkg::OP_LOAD_B);
    assign o_x_we    = in_fire && (i_in.operation == mme_pkg::OP_ROW_A);
    assign o_w_waddr = r_load_pos;
    assign o_x_waddr = r_fill_pos;
    assign o_wdata   = i_in.value;

    assign o_tag.valid     = (r_state == S_RUN);
    assign o_tag.first     = (r_k == '0);
    assign o_tag.last      = k_end;
    assign o_tag.last_col  = j_end;
    assign o_tag.final_row = r_final;
    assign o_w_raddr       = r_addr;
    assign o_x_raddr       = r_k;
    assign o_col           = r_j;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_inner_size <= mme_pkg::DIM_RESET;
            r_out_cols   <= mme_pkg::DIM_RESET;
            r_left_rows  <= mme_pkg::DIM_RESET;
            r_load_pos   <= '0;
            r_fill_pos   <= '0;
            r_rows_done  <= '0;
            r_final      <= 1'b0;
            r_k          <= '0;
            r_j          <= '0;
            r_addr       <= '0;
        end else begin
            if (cfg_fire && cfg_hit) begin
                unique case (i_cfg.index)
                    mme_pkg::REG_INNER_SIZE: r_inner_size <= i_cfg.data;
                    mme_pkg::REG_OUT_COLS:   r_out_cols   <= i_cfg.data;
                    default:                 r_left_rows  <= i_cfg.data;
                endcase
                r_load_pos  <= '0;
                r_fill_pos  <= '0;
                r_rows_done <= '0;
            end else if (in_fire) begin
                if (i_in.operation == mme_pkg::OP_LOAD_B) begin
                    r_load_pos <= (load_inc >= total) ? '0 : r_load_pos + AW'(1);
                end else if (!row_done) begin
                    r_fill_pos <= r_fill_pos + IW'(1);
                end else begin
                    r_fill_pos  <= '0;
                    r_final     <= (rows_inc >= n_rows);
                    r_rows_done <= (rows_inc >= n_rows) ? '0 : r_rows_done + IW'(1);
                    r_state     <= S_RUN;
                    r_k         <= '0;
                    r_j         <= '0;
                    r_addr      <= '0;
                end
            end else if ((r_state == S_RUN) && i_pipe_en) begin
                if (!k_end) begin
                    r_k    <= r_k + IW'(1);
                    r_addr <= r_addr + AW'(n_out);
                end else begin
                    r_k    <= '0;
                    r_addr <= AW'(r_j) + AW'(1);
                    r_j    <= r_j + IW'(1);
                    if (j_end) begin
                        r_state <= S_IDLE;
                    end
                end
            end
        end
    end

endmodule

[src/mme_mac.sv]
// Datapath: weight and row memories, shared multiplier, accumulator with
// Q16.16 saturation and the result register. Depends on mme_pkg, mme_if.
module mme_mac #(
    parameter int MAX_DIM = mme_pkg::MAX_DIM_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_w_we,
    input  logic [$clog2(MAX_DIM*MAX_DIM)-1:0] i_w_waddr,
    input  logic                             i_x_we,
    input  logic [$clog2(MAX_DIM)-1:0]       i_x_waddr,
    input  logic signed [mme_pkg::VAL_W-1:0] i_wdata,
    input  mme_pkg::t_tag                    i_tag,
    input  logic [$clog2(MAX_DIM*MAX_DIM)-1:0] i_w_raddr,
    input  logic [$clog2(MAX_DIM)-1:0]       i_x_raddr,
    input  logic [$clog2(MAX_DIM)-1:0]       i_col,
    output logic                             o_pipe_en,
    mme_out_if.source                        o_out
);
    localparam int IW    = $clog2(MAX_DIM);
    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int ACC_W = 33 + $clog2(MAX_DIM);
    localparam int PW    = mme_pkg::PROD_W;

    localparam logic signed [ACC_W-1:0] SAT_HI = {{(ACC_W-PW+1){1'b0}}, {(PW-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SAT_LO = {{(ACC_W-PW+1){1'b1}}, {(PW-1){1'b0}}};

    logic signed [mme_pkg::VAL_W-1:0] r_wmem [DEPTH];
    logic signed [mme_pkg::VAL_W-1:0] r_xmem [MAX_DIM];

    logic signed [mme_pkg::VAL_W-1:0] r_w, r_x;
    logic signed [PW-1:0]             r_prod;
    logic signed [ACC_W-1:0]          r_acc;
    mme_pkg::t_tag                    r_t1, r_t2;
    logic [IW-1:0]                    r_col1, r_col2;

    logic                             r_ovalid;
    logic signed [PW-1:0]             r_oprod;
    logic [mme_pkg::COL_W-1:0]        r_ocol;
    logic                             r_olast, r_ofinal, r_osat;

    logic signed [ACC_W-1:0]          sum;
    logic                             sat_hi, sat_lo, emit;
    logic [IW+mme_pkg::COL_W-1:0]     col_ext;

    assign o_pipe_en = !(r_t2.valid && r_t2.last && r_ovalid && !o_out.ready);
    assign emit      = o_pipe_en && r_t2.valid && r_t2.last;
    assign sum       = (r_t2.first ? '0 : r_acc) + ACC_W'(r_prod);
    assign sat_hi    = sum > SAT_HI;
    assign sat_lo    = sum < SAT_LO;
    assign col_ext   = (IW + mme_pkg::COL_W)'(r_col2);

    always_ff @(posedge i_clk) begin
        if (i_w_we) begin
            r_wmem[i_w_waddr] <= i_wdata;
        end
        if (i_x_we) begin
            r_xmem[i_x_waddr] <= i_wdata;
        end
        if (o_pipe_en) begin
            r_w    <= r_wmem[i_w_raddr];
            r_x    <= r_xmem[i_x_raddr];
            r_col1 <= i_col;
            r_prod <= r_x * r_w;
            r_col2 <= r_col1;
            if (r_t2.valid && !r_t2.last) begin
                r_acc <= sum;
            end
        end
        if (emit) begin
            r_oprod  <= sat_hi ? SAT_HI[PW-1:0] : sat_lo ? SAT_LO[PW-1:0] : sum[PW-1:0];
            r_osat   <= sat_hi || sat_lo;
            r_ocol   <= col_ext[mme_pkg::COL_W-1:0];
            r_olast  <= r_t2.last_col;
            r_ofinal <= r_t2.final_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t1     <= '0;
            r_t2     <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (o_pipe_en) begin
                r_t1 <= i_tag;
                r_t2 <= r_t1;
            end
            if (emit) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_out.valid     = r_ovalid;
    assign o_out.product   = r_oprod;
    assign o_out.column    = r_ocol;
    assign o_out.last      = r_olast;
    assign o_out.final_row = r_ofinal;
    assign o_out.saturated = r_osat;

endmodule

[src/matrix_multiply_engine.sv]
// Top level of the matrix multiply engine: sequencer and MAC datapath.
// Depends on mme_pkg, mme_if, mme_seq, mme_mac.
//
// Usage: write inner_size, out_cols and left_rows on i_cfg while idle; each
// write restarts the B load, row fill and row count. Then send B elements
// (operation 0) in row-major order, then rows of A (operation 1) on i_in.
// When an A element completes a row, the block emits out_cols items on
// o_out, one per column in ascending order, last marking the row's end and
// final_row set on every item of the last row of the product.
// Flow: B loads and A elements are accepted whenever the block is idle.
// The row-ending element keeps i_in not ready until the single shared
// multiply-accumulate unit has made one pass per term for the whole row;
// each result goes through the operand and product registers, adds to the
// accumulator and is held in the result register.
// Reset: configuration returns to 16/16/16 and all counters to zero; the
// memories keep their contents and are valid only once written.
// Stall: the result register holds while o_out.ready is low; when the next
// result is due the MAC pipeline freezes and no item is lost.
module matrix_multiply_engine #(
    parameter int MAX_DIM = mme_pkg::MAX_DIM_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mme_in_if.sink    i_in,
    mme_cfg_if.sink   i_cfg,
    mme_out_if.source o_out
);
    localparam int IW = $clog2(MAX_DIM);
    localparam int AW = $clog2(MAX_DIM * MAX_DIM);

    logic                             pipe_en;
    logic                             w_we, x_we;
    logic [AW-1:0]                    w_waddr, w_raddr;
    logic [IW-1:0]                    x_waddr, x_raddr, col;
    logic signed [mme_pkg::VAL_W-1:0] wdata;
    mme_pkg::t_tag                    tag;

    mme_seq #(.MAX_DIM(MAX_DIM)) u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_cfg     (i_cfg),
        .i_pipe_en (pipe_en),
        .o_w_we    (w_we),
        .o_w_waddr (w_waddr),
        .o_x_we    (x_we),
        .o_x_waddr (x_waddr),
        .o_wdata   (wdata),
        .o_tag     (tag),
        .o_w_raddr (w_raddr),
        .o_x_raddr (x_raddr),
        .o_col     (col)
    );

    mme_mac #(.MAX_DIM(MAX_DIM)) u_mac (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_w_we    (w_we),
        .i_w_waddr (w_waddr),
        .i_x_we    (x_we),
        .i_x_waddr (x_waddr),
        .i_wdata   (wdata),
        .i_tag     (tag),
        .i_w_raddr (w_raddr),
        .i_x_raddr (x_raddr),
        .i_col     (col),
        .o_pipe_en (pipe_en),
        .o_out     (o_out)
    );

endmodule

[dv/tb.sv]
`timescale 1ns / 100ps
// Testbench for matrix_multiply_engine: loads B, streams rows of A under random
// idling and stalls, and checks each product item against an in-bench predictor.
// Depends on mme_pkg, the mme_if interfaces and the engine RTL.
module tb;
    import mme_pkg::*;

    localparam int ITEM_GOAL  = 310;
    localparam int IDLE_LIMIT = 2000;
    localparam int SETTLE_CYC = 24;
    localparam int MAX_SHOWN  = 10;
    localparam int STORE_SZ   = MAX_DIM_DEF * MAX_DIM_DEF;
    localparam logic [IDX_W-1:0] REG_SPARE = 2'd3;
    localparam longint Q_MAX = (64'sd1 <<< 31) - 64'sd1;
    localparam longint Q_MIN = -(64'sd1 <<< 31);

    typedef struct {
        logic signed [PROD_W-1:0] product;
        logic [COL_W-1:0]         column;
        logic                     last;
        logic                     final_row;
        logic                     saturated;
    } t_prod;

    typedef struct {
        logic                     op;
        logic signed [VAL_W-1:0]  value;
        bit                       typed;
        logic signed [PROD_W-1:0] product;
        logic                     saturated;
    } t_elem;

    typedef struct {
        logic [CFG_W-1:0] inner;
        logic [CFG_W-1:0] cols;
        logic [CFG_W-1:0] rows;
        bit               hot;
    } t_shape;

    typedef enum {SINK_OPEN, SINK_COIN, SINK_MOSTLY, SINK_HOLD} t_sink_mode;

    logic i_clk;
    logic i_rst_n;

    mme_in_if  in_ch();
    mme_cfg_if cfg_ch();
    mme_out_if out_ch();

    matrix_multiply_engine dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_out   (out_ch)
    );

    // predictor state
    logic [CFG_W-1:0]        reg_inner;
    logic [CFG_W-1:0]        reg_cols;
    logic [CFG_W-1:0]        reg_rows;
    logic signed [VAL_W-1:0] b_store [STORE_SZ];
    bit                      b_written [STORE_SZ];
    logic signed [VAL_W-1:0] a_row [MAX_DIM_DEF];
    int                      b_pos;
    int                      a_pos;
    int                      row_cnt;
    t_prod                   product_q[$];

    int         n_bad;
    int         items_sent;
    int         idle_cnt;
    int         burst_left;
    int         stall_run;
    t_sink_mode stall_mode;

    // 2x2x2 product: positive clip, zero row, B reload between A elements
    t_elem bench_rows [13] = '{
        '{OP_LOAD_B, 16'sh8000, 1'b0, 32'sh0, 1'b0},
        '{OP_LOAD_B, 16'sh0100, 1'b0, 32'sh0, 1'b0},
        '{OP_LOAD_B, 16'sh8000, 1'b0, 32'sh0, 1'b0},
        '{OP_LOAD_B, 16'sh7FFF, 1'b0, 32'sh0, 1'b0},
        '{OP_ROW_A,  16'sh8000, 1'b0, 32'sh0, 1'b0},
        '{OP_ROW_A,  16'sh8000, 1'b1, 32'sh7FFFFFFF, 1'b1},
        '{OP_ROW_A,  16'sh0000, 1'b0, 32'sh0, 1'b0},
        '{OP_ROW_A,  16'sh0000, 1'b1, 32'sh0, 1'b0},
        '{OP_ROW_A,  16'sh0100, 1'b0, 32'sh0, 1'b0},
        '{OP_LOAD_B, 16'sh7FFF, 1'b0, 32'sh0, 1'b0},
        '{OP_ROW_A,  16'shFFFF, 1'b0, 32'sh0, 1'b0},
        '{OP_ROW_A,  16'sh7FFF, 1'b0, 32'sh0, 1'b0},
        '{OP_ROW_A,  16'sh0001, 1'b0, 32'sh0, 1'b0}
    };

    t_shape fixed_shapes [4] = '{
        '{5'd0,  5'd0,  5'd0,  1'b0},
        '{5'd1,  5'd31, 5'd31, 1'b0},
        '{5'd17, 5'd1,  5'd3,  1'b0},
        '{5'd4,  5'd4,  5'd2,  1'b1}
    };

    function automatic int dim_of_reg(logic [CFG_W-1:0] r);
        if (r == 0) return 1;
        if (r > MAX_DIM_DEF) return MAX_DIM_DEF;
        return int'(r);
    endfunction

    function automatic void cfg_predict(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] d);
        case (idx)
            REG_INNER_SIZE: reg_inner = d;
            REG_OUT_COLS:   reg_cols = d;
            REG_LEFT_ROWS:  reg_rows = d;
            default:        return;
        endcase
        b_pos = 0;
        a_pos = 0;
        row_cnt = 0;
    endfunction

    function automatic int mac_predict(logic op, logic signed [VAL_W-1:0] v);
        int     ni;
        int     nc;
        int     nr;
        longint acc;
        t_prod  p;
        ni = dim_of_reg(reg_inner);
        nc = dim_of_reg(reg_cols);
        nr = dim_of_reg(reg_rows);
        if (op == OP_LOAD_B) begin
            if (b_pos >= ni * nc) b_pos = 0;
            b_store[b_pos] = v;
            b_written[b_pos] = 1'b1;
            b_pos++;
            if (b_pos >= ni * nc) b_pos = 0;
            return 0;
        end
        if (a_pos >= ni) a_pos = 0;
        a_row[a_pos] = v;
        a_pos++;
        if (a_pos < ni) return 0;
        a_pos = 0;
        if (row_cnt >= nr) row_cnt = 0;
        for (int j = 0; j < nc; j++) begin
            acc = 0;
            for (int k = 0; k < ni; k++) begin
                acc += longint'(a_row[k]) * longint'(b_store[k * nc + j]);
            end
            p.saturated = 1'b0;
            if (acc > Q_MAX) begin
                acc = Q_MAX;
                p.saturated = 1'b1;
            end
            if (acc < Q_MIN) begin
                acc = Q_MIN;
                p.saturated = 1'b1;
            end
            p.product = acc[PROD_W-1:0];
            p.column = j[COL_W-1:0];
            p.last = (j == nc - 1);
            p.final_row = (row_cnt == nr - 1);
            product_q.push_back(p);
        end
        row_cnt++;
        if (row_cnt >= nr) row_cnt = 0;
        return nc;
    endfunction

    function automatic bit b_complete();
        int ni;
        int nc;
        ni = dim_of_reg(reg_inner);
        nc = dim_of_reg(reg_cols);
        for (int i = 0; i < ni * nc; i++) begin
            if (!b_written[i]) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic logic signed [VAL_W-1:0] pick_value(bit hot);
        if (hot && $urandom_range(0, 4) != 0) begin
            return ($urandom_range(0, 1) != 0) ? 16'sh7FFF : 16'sh8000;
        end
        case ($urandom_range(0, 9))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return '0;
            3:       return '1;
            4, 5:    return VAL_W'($urandom_range(0, 1023)) - 16'sd512;
            default: return VAL_W'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_dim(int hi);
        if ($urandom_range(0, 9) == 0) begin
            return ($urandom_range(0, 1) != 0) ? '0 : CFG_W'($urandom_range(17, 31));
        end
        return CFG_W'($urandom_range(1, hi));
    endfunction

    task automatic send_elem(input logic op, input logic signed [VAL_W-1:0] v,
                             output int n_new);
        if (burst_left == 0) begin
            if ($urandom_range(0, 2) != 0) begin
                in_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 10);
        end
        burst_left--;
        in_ch.valid     <= 1'b1;
        in_ch.operation <= op;
        in_ch.value     <= v;
        @(posedge i_clk);
        while (in_ch.ready !== 1'b1) @(posedge i_clk);
        items_sent++;
        n_new = mac_predict(op, v);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] d);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= d;
        @(posedge i_clk);
        while (cfg_ch.ready !== 1'b1) @(posedge i_clk);
        cfg_predict(idx, d);
    endtask

    task automatic set_dims(input logic [CFG_W-1:0] ri, input logic [CFG_W-1:0] rc,
                            input logic [CFG_W-1:0] rr, input bit spare);
        if (spare) write_reg(REG_SPARE, CFG_W'($urandom));
        write_reg(REG_INNER_SIZE, ri);
        write_reg(REG_OUT_COLS, rc);
        write_reg(REG_LEFT_ROWS, rr);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic settle();
        in_ch.valid <= 1'b0;
        burst_left = 0;
        while (product_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin : stimulus
        int     n;
        int     ni;
        int     nr;
        int     nrows;
        int     nload;
        int     phase;
        t_shape sh;
        i_rst_n         <= 1'b0;
        in_ch.valid     <= 1'b0;
        in_ch.operation <= OP_LOAD_B;
        in_ch.value     <= '0;
        cfg_ch.valid    <= 1'b0;
        cfg_ch.index    <= REG_INNER_SIZE;
        cfg_ch.data     <= '0;
        reg_inner = DIM_RESET;
        reg_cols  = DIM_RESET;
        reg_rows  = DIM_RESET;
        b_pos = 0;
        a_pos = 0;
        row_cnt = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        set_dims(5'd2, 5'd2, 5'd2, 1'b0);
        foreach (bench_rows[i]) begin
            send_elem(bench_rows[i].op, bench_rows[i].value, n);
            if (bench_rows[i].typed) begin
                product_q[product_q.size() - n].product   = bench_rows[i].product;
                product_q[product_q.size() - n].saturated = bench_rows[i].saturated;
            end
        end

        phase = 0;
        while (items_sent < ITEM_GOAL) begin
            if (phase < 4) begin
                sh = fixed_shapes[phase];
            end else begin
                sh = '{pick_dim(6), pick_dim(6), pick_dim(5), $urandom_range(0, 7) == 0};
            end
            settle();
            set_dims(sh.inner, sh.cols, sh.rows, phase == 0);
            ni = dim_of_reg(reg_inner);
            nr = dim_of_reg(reg_rows);
            nload = ni * dim_of_reg(reg_cols);
            // a partial reload is only legal once the whole B is in place
            if (b_complete() && $urandom_range(0, 4) == 0) nload = $urandom_range(0, nload - 1);
            repeat (nload) send_elem(OP_LOAD_B, pick_value(sh.hot), n);
            nrows = $urandom_range(1, nr + 2);
            repeat (nrows) begin
                for (int e = 0; e < ni; e++) begin
                    if ($urandom_range(0, 15) == 0) send_elem(OP_LOAD_B, pick_value(sh.hot), n);
                    send_elem(OP_ROW_A, pick_value(sh.hot), n);
                end
            end
            if ($urandom_range(0, 4) == 0) begin
                repeat ($urandom_range(0, ni - 1)) send_elem(OP_ROW_A, pick_value(sh.hot), n);
            end
            phase++;
        end
        settle();

        if (n_bad == 0 && product_q.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    always @(posedge i_clk) begin : sink_stall
        if (stall_run == 0) begin
            stall_mode = t_sink_mode'($urandom_range(0, 3));
            stall_run = (stall_mode == SINK_HOLD) ? $urandom_range(1, 20) : $urandom_range(5, 60);
        end
        stall_run--;
        case (stall_mode)
            SINK_OPEN:   out_ch.ready <= 1'b1;
            SINK_COIN:   out_ch.ready <= ($urandom_range(0, 1) != 0);
            SINK_MOSTLY: out_ch.ready <= ($urandom_range(0, 7) != 0);
            default:     out_ch.ready <= 1'b0;
        endcase
    end

    always @(posedge i_clk) begin : check_products
        t_prod want;
        if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            if (product_q.size() == 0) begin
                n_bad++;
                if (n_bad <= MAX_SHOWN) begin
                    $display("%0t: unexpected product item %h col %0d", $time,
                             out_ch.product, out_ch.column);
                end
            end else begin
                want = product_q.pop_front();
                if (out_ch.product !== want.product || out_ch.column !== want.column ||
                    out_ch.last !== want.last || out_ch.final_row !== want.final_row ||
                    out_ch.saturated !== want.saturated) begin
                    n_bad++;
                    if (n_bad <= MAX_SHOWN) begin
                        // fields: product/column/last/final_row/saturated
                        $display("%0t: got %h/%0d/%b/%b/%b want %h/%0d/%b/%b/%b",
                                 $time, out_ch.product, out_ch.column, out_ch.last,
                                 out_ch.final_row, out_ch.saturated, want.product,
                                 want.column, want.last, want.final_row, want.saturated);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        if ((in_ch.valid & in_ch.ready) === 1'b1 || (out_ch.valid & out_ch.ready) === 1'b1 ||
            (cfg_ch.valid & cfg_ch.ready) === 1'b1) begin
            idle_cnt = 0;
        end else begin
            idle_cnt++;
        end
        if (idle_cnt >= IDLE_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
            $display("Mismatches found");
            $finish;
        end
    end

endmodule

[files.f]
src/mme_pkg.sv
src/mme_if.sv
src/mme_seq.sv
src/mme_mac.sv
src/matrix_multiply_engine.sv
dv/tb.sv
